FILE: hdl/tcw_pkg.sv
// shared types, codes and defaults of the text console writer
`default_nettype none

package tcw_pkg;

    // default screen geometry
    localparam int DefColumns = 80;
    localparam int DefRows    = 25;

    // action codes
    localparam logic [1:0] ActPut   = 2'd0;
    localparam logic [1:0] ActClear = 2'd1;
    localparam logic [1:0] ActRead  = 2'd2;

    // character codes with a meaning of their own
    localparam logic [7:0] CharNl    = 8'h0A;
    localparam logic [7:0] CharCr    = 8'h0D;
    localparam logic [7:0] CharBs    = 8'h08;
    localparam logic [7:0] BlankChar = 8'h20;

    // attribute after reset
    localparam logic [7:0] ResetAttr = 8'h07;

    // one screen cell: attribute in the high byte, character in the low byte
    typedef logic [15:0] cell_t;

    function automatic cell_t make_cell(input logic [7:0] ch, input logic [7:0] attr);
        return {attr, ch};
    endfunction

endpackage

`default_nettype wire

FILE: hdl/text_console_writer_core.sv
// text console writer: screen store, cursor and put/clear/read sequencer
//
// Text console writer. Keeps a ROWS x COLUMNS screen of 16-bit cells
// (attribute in the high byte, character in the low byte) in one synchronous
// dual-port memory, plus a cursor. Each input transfer carries an action: put
// a character, clear the screen with a given attribute, or read one cell; each
// transfer gives exactly one result transfer with the cursor after the step and
// the cell read (zero for other actions). An ordinary put, a control byte and a
// read take the accept, then one memory access. A clear writes all ROWS*COLUMNS
// cells, one cell written per cycle. A put that moves the cursor past the last
// row scrolls the screen: one cell copied per cycle through the memory read
// port; then, for a printable character, the character is written into the new
// bottom row. After reset a clearing pass writes blanks with attribute 0x07
// into all ROWS*COLUMNS cells, during which in_stall stays high. The result
// sits in an output register, so the next item is accepted while an earlier
// result still waits. The attribute register for written characters and
// blanks is loaded through the cfg channel, which is always ready; write it
// only while the block is idle.
`default_nettype none

module text_console_writer_core
    import tcw_pkg::*;
#(
    parameter int COLUMNS = DefColumns,
    parameter int ROWS    = DefRows
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    // attribute register write channel
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_data,

    // input items
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  action,
    input  wire logic [7:0]  char_code,
    input  wire logic [7:0]  clear_attr,
    input  wire logic [10:0] cell_index,

    // result items
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [6:0]       cursor_col,
    output logic [4:0]       cursor_row,
    output logic [15:0]      read_data
);

    localparam int CellCount = ROWS * COLUMNS;
    localparam int AW        = $clog2(CellCount);
    localparam int CW        = $clog2(COLUMNS + 1);   // column may equal COLUMNS
    localparam int RW        = $clog2(ROWS);

    localparam logic [AW-1:0] LastCell   = AW'(CellCount - 1);
    localparam logic [AW-1:0] BottomBase = AW'(CellCount - COLUMNS);
    localparam logic [AW-1:0] RowStep    = AW'(COLUMNS);
    localparam logic [CW-1:0] ColWrap    = CW'(COLUMNS);
    localparam logic [RW-1:0] LastRow    = RW'(ROWS - 1);

    // sequencer states
    localparam logic [2:0] S_INIT   = 3'd0;   // clearing pass after reset
    localparam logic [2:0] S_IDLE   = 3'd1;   // waiting for an input transfer
    localparam logic [2:0] S_EXEC   = 3'd2;   // one memory access for the item
    localparam logic [2:0] S_FILL   = 3'd3;   // clear action sweep
    localparam logic [2:0] S_SCROLL = 3'd4;   // copy rows up, blank bottom row
    localparam logic [2:0] S_DRAIN  = 3'd5;   // last scroll write lands
    localparam logic [2:0] S_POST   = 3'd6;   // character after a scroll
    localparam logic [2:0] S_HOLD   = 3'd7;   // result waits for the output register

    // screen memory
    cell_t           mem [CellCount];
    cell_t           rdata_reg;
    logic [AW-1:0]   mem_raddr;
    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    cell_t           mem_wdata;

    // control and item registers
    logic [2:0]      state_reg, state_next;
    logic [AW-1:0]   cnt_reg, cnt_next;
    logic [CW-1:0]   col_reg, col_next;
    logic [RW-1:0]   row_reg, row_next;
    logic [7:0]      attr_reg;
    logic [1:0]      act_reg, act_next;
    logic [7:0]      chr_reg, chr_next;
    logic [7:0]      fill_reg, fill_next;
    logic            rd_ok_reg, rd_ok_next;
    logic            post_reg, post_next;
    cell_t           rd_reg, rd_next;

    // delayed write of the scroll copy (the read data is registered)
    logic            wp_vld_reg, wp_vld_next;
    logic [AW-1:0]   wp_addr_reg, wp_addr_next;
    logic            wp_copy_reg, wp_copy_next;

    // output register
    logic            out_valid_reg, out_valid_next;
    logic [6:0]      out_col_reg, out_col_next;
    logic [4:0]      out_row_reg, out_row_next;
    cell_t           out_rd_reg, out_rd_next;

    logic            fin;
    logic            slot_free;

    // memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_raddr];
    end

    // scroll reads one row ahead; otherwise the read item's cell is fetched
    // in the accept cycle so the data is there in the execute cycle
    assign mem_raddr = (state_reg == S_SCROLL) ? (cnt_reg + RowStep) : AW'(cell_index);

    assign slot_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        logic [RW-1:0] row_eff;
        logic [CW-1:0] col_eff;

        row_eff        = row_reg;
        col_eff        = col_reg;

        state_next     = state_reg;
        cnt_next       = cnt_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        act_next       = act_reg;
        chr_next       = chr_reg;
        fill_next      = fill_reg;
        rd_ok_next     = rd_ok_reg;
        post_next      = post_reg;
        rd_next        = rd_reg;
        wp_vld_next    = 1'b0;
        wp_addr_next   = wp_addr_reg;
        wp_copy_next   = wp_copy_reg;
        fin            = 1'b0;

        mem_we         = 1'b0;
        mem_waddr      = cnt_reg;
        mem_wdata      = make_cell(BlankChar, attr_reg);

        case (state_reg)
            S_INIT:
            begin
                mem_we    = 1'b1;
                mem_waddr = cnt_reg;
                mem_wdata = make_cell(BlankChar, ResetAttr);
                cnt_next  = cnt_reg + AW'(1);
                if (cnt_reg == LastCell)
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (in_valid)
                begin
                    act_next   = action;
                    chr_next   = char_code;
                    fill_next  = clear_attr;
                    rd_ok_next = (32'(cell_index) < 32'(CellCount));
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                rd_next = '0;
                case (act_reg)
                    ActPut:
                    begin
                        case (chr_reg)
                            CharNl:
                            begin
                                col_next = '0;
                                if (row_reg == LastRow)
                                begin
                                    post_next  = 1'b0;
                                    cnt_next   = '0;
                                    state_next = S_SCROLL;
                                end
                                else
                                begin
                                    row_next = row_reg + RW'(1);
                                    fin      = 1'b1;
                                end
                            end

                            CharCr:
                            begin
                                col_next = '0;
                                fin      = 1'b1;
                            end

                            CharBs:
                            begin
                                // at a pending wrap this lands on the last column
                                if (col_reg != '0)
                                begin
                                    col_eff = col_reg - CW'(1);
                                end
                                mem_we    = 1'b1;
                                mem_waddr = AW'(row_eff) * RowStep + AW'(col_eff);
                                mem_wdata = make_cell(BlankChar, attr_reg);
                                col_next  = col_eff;
                                fin       = 1'b1;
                            end

                            default:
                            begin
                                if (chr_reg >= BlankChar)
                                begin
                                    if (col_reg == ColWrap && row_reg == LastRow)
                                    begin
                                        // wrap off the bottom: scroll, then write
                                        post_next  = 1'b1;
                                        cnt_next   = '0;
                                        state_next = S_SCROLL;
                                    end
                                    else
                                    begin
                                        if (col_reg == ColWrap)
                                        begin
                                            row_eff = row_reg + RW'(1);
                                            col_eff = '0;
                                        end
                                        mem_we    = 1'b1;
                                        mem_waddr = AW'(row_eff) * RowStep + AW'(col_eff);
                                        mem_wdata = make_cell(chr_reg, attr_reg);
                                        row_next  = row_eff;
                                        col_next  = col_eff + CW'(1);
                                        fin       = 1'b1;
                                    end
                                end
                                else
                                begin
                                    // other control bytes change nothing
                                    fin = 1'b1;
                                end
                            end
                        endcase
                    end

                    ActClear:
                    begin
                        cnt_next   = '0;
                        state_next = S_FILL;
                    end

                    ActRead:
                    begin
                        rd_next = rd_ok_reg ? rdata_reg : '0;
                        fin     = 1'b1;
                    end

                    default:
                    begin
                        fin = 1'b1;
                    end
                endcase
            end

            S_FILL:
            begin
                mem_we    = 1'b1;
                mem_waddr = cnt_reg;
                mem_wdata = make_cell(BlankChar, fill_reg);
                cnt_next  = cnt_reg + AW'(1);
                if (cnt_reg == LastCell)
                begin
                    col_next = '0;
                    row_next = '0;
                    fin      = 1'b1;
                end
            end

            S_SCROLL:
            begin
                // cell i takes cell i+COLUMNS, bottom row takes blanks
                wp_vld_next  = 1'b1;
                wp_addr_next = cnt_reg;
                wp_copy_next = (cnt_reg < BottomBase);
                cnt_next     = cnt_reg + AW'(1);
                if (cnt_reg == LastCell)
                begin
                    state_next = S_DRAIN;
                end
            end

            S_DRAIN:
            begin
                row_next = LastRow;
                col_next = '0;
                if (post_reg)
                begin
                    state_next = S_POST;
                end
                else
                begin
                    fin = 1'b1;
                end
            end

            S_POST:
            begin
                mem_we    = 1'b1;
                mem_waddr = BottomBase;
                mem_wdata = make_cell(chr_reg, attr_reg);
                col_next  = CW'(1);
                fin       = 1'b1;
            end

            S_HOLD:
            begin
                fin = 1'b1;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // pending scroll write owns the port in its cycles
        if (wp_vld_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = wp_addr_reg;
            mem_wdata = wp_copy_reg ? rdata_reg : make_cell(BlankChar, attr_reg);
        end

        if (fin)
        begin
            state_next = slot_free ? S_IDLE : S_HOLD;
        end
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        out_col_next   = out_col_reg;
        out_row_next   = out_row_reg;
        out_rd_next    = out_rd_reg;
        if (fin && slot_free)
        begin
            out_valid_next = 1'b1;
            out_col_next   = 7'(col_next);
            out_row_next   = 5'(row_next);
            out_rd_next    = rd_next;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            cnt_reg       <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            attr_reg      <= ResetAttr;
            wp_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            wp_vld_reg    <= wp_vld_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid)
            begin
                attr_reg <= cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        act_reg     <= act_next;
        chr_reg     <= chr_next;
        fill_reg    <= fill_next;
        rd_ok_reg   <= rd_ok_next;
        post_reg    <= post_next;
        rd_reg      <= rd_next;
        wp_addr_reg <= wp_addr_next;
        wp_copy_reg <= wp_copy_next;
        out_col_reg <= out_col_next;
        out_row_reg <= out_row_next;
        out_rd_reg  <= out_rd_next;
    end

    assign cfg_ready  = 1'b1;
    assign in_stall   = (state_reg != S_IDLE);
    assign out_valid  = out_valid_reg;
    assign cursor_col = out_col_reg;
    assign cursor_row = out_row_reg;
    assign read_data  = out_rd_reg;

endmodule

`default_nettype wire

FILE: hdl/tcw_checker.sv
// port-level assertions of the text console writer and their bind
`default_nettype none

module tcw_checker
    import tcw_pkg::*;
#(
    parameter int COLUMNS = DefColumns,
    parameter int ROWS    = DefRows
)
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [6:0]  cursor_col,
    input wire logic [4:0]  cursor_row,
    input wire logic [15:0] read_data
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(cursor_col)
            && $stable(cursor_row) && $stable(read_data))
        else $error("stalled result changed");

    // one item at a time: busy right after an accepted transfer
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input not stalled after accept");

    // a result only appears out of a busy cycle
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result without work");

    // cursor row stays on the screen, column at most COLUMNS (pending wrap)
    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (COLUMNS > 127 || 32'(cursor_col) <= COLUMNS)
            && (ROWS > 32 || 32'(cursor_row) < ROWS))
        else $error("cursor off screen");

endmodule

bind text_console_writer_core tcw_checker #(
    .COLUMNS(COLUMNS),
    .ROWS(ROWS)
) u_tcw_checker (.*);

`default_nettype wire
